### design/rar_pkg.sv
// rar_pkg: shared types, codes and widths for the rational add/reduce unit
// depends on nothing; used by every module in the design folder
package rar_pkg;

    localparam int unsigned OPERAND_WIDTH_DEFAULT = 32;
    localparam int unsigned FIELD_WIDTH = 32;
    localparam int unsigned MAG_WIDTH = 2 * FIELD_WIDTH + 1;

    typedef enum logic [1:0] {
        KIND_ADD      = 2'd0,
        KIND_EQUALS   = 2'd1,
        KIND_INCR     = 2'd2,
        KIND_SIMPLIFY = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture operands, decode
        logic mul_step;   // form products
        logic combine;    // form sum magnitude and denominator
        logic gcd_start;  // start divider pass for gcd
        logic div_step;   // one shift-subtract step
        logic gcd_swap;   // x <= y, y <= remainder
        logic quot_start; // divide numerator/denominator by gcd
        logic quot_next;  // second quotient
        logic finish;     // form result
    } rar_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic      early;    // result already known after decode
        logic      div_done;
        logic      y_zero;
    } rar_sts_t;

endpackage

### design/rar_ctrl.sv
// rar_ctrl: controller state machine of the rational add/reduce unit
// depends on rar_pkg; drives rar_datapath through command/status structs
module rar_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_fire,
    input  logic              m_free,
    input  rar_pkg::rar_sts_t sts,
    output rar_pkg::rar_cmd_t cmd,
    output logic              busy,
    output logic              out_load
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_COMB, ST_GCD_CHK, ST_GCD_DIV, ST_Q1, ST_Q1_RUN,
        ST_Q2_RUN, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE:    if (s_fire) state_reg <= ST_MUL;
                ST_MUL:     state_reg <= sts.early ? ST_OUT : ST_COMB;
                ST_COMB:    state_reg <= ST_GCD_CHK;
                ST_GCD_CHK: state_reg <= sts.y_zero ? ST_Q1 : ST_GCD_DIV;
                ST_GCD_DIV: if (sts.div_done) state_reg <= ST_GCD_CHK;
                ST_Q1:      state_reg <= ST_Q1_RUN;
                ST_Q1_RUN:  if (sts.div_done) state_reg <= ST_Q2_RUN;
                ST_Q2_RUN:  if (sts.div_done) state_reg <= ST_FIN;
                ST_FIN:     state_reg <= ST_OUT;
                ST_OUT:     if (m_free) state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd = '0;
        cmd.load       = s_fire;
        cmd.mul_step   = (state_reg == ST_MUL);
        cmd.combine    = (state_reg == ST_COMB);
        cmd.gcd_start  = (state_reg == ST_GCD_CHK) && !sts.y_zero;
        cmd.div_step   = (state_reg == ST_GCD_DIV) || (state_reg == ST_Q1_RUN)
                         || (state_reg == ST_Q2_RUN);
        cmd.gcd_swap   = (state_reg == ST_GCD_DIV) && sts.div_done;
        cmd.quot_start = (state_reg == ST_Q1);
        cmd.quot_next  = (state_reg == ST_Q1_RUN) && sts.div_done;
        cmd.finish     = (state_reg == ST_FIN);
    end

    assign busy     = (state_reg != ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && m_free;

endmodule

### design/rar_datapath.sv
// rar_datapath: operand registers, multiplier, shared restoring divider and result logic
// depends on rar_pkg; sequenced by rar_ctrl
module rar_datapath #(
    parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rar_pkg::rar_cmd_t                   cmd,
    output rar_pkg::rar_sts_t                   sts,
    input  logic [1:0]                          kind,
    input  logic [rar_pkg::FIELD_WIDTH-1:0]     an_in,
    input  logic [rar_pkg::FIELD_WIDTH-1:0]     ad_in,
    input  logic [rar_pkg::FIELD_WIDTH-1:0]     bn_in,
    input  logic [rar_pkg::FIELD_WIDTH-1:0]     bd_in,
    output logic [rar_pkg::FIELD_WIDTH-1:0]     res_num,
    output logic [rar_pkg::FIELD_WIDTH-1:0]     res_den,
    output logic                                res_eq,
    output logic [1:0]                          res_status
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned DW = 2 * W;              // product width
    localparam int unsigned MW = 2 * W + 1;          // sum magnitude width
    localparam int unsigned CW = $clog2(MW + 1);
    localparam int unsigned FW = rar_pkg::FIELD_WIDTH;

    logic [1:0]          kind_reg;
    logic signed [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [DW-1:0] p_reg, q_reg;
    logic [1:0]          st_reg;
    logic                eq_reg, neg_reg;
    logic [MW-1:0]       nmag_reg, dmag_reg;
    logic [MW-1:0]       x_reg, y_reg;
    // divider
    logic [MW-1:0]       dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [CW-1:0]       cnt_reg;
    logic                run_reg;
    logic [MW-1:0]       g_reg, q1_reg;
    logic [FW-1:0]       num_reg, den_reg;

    function automatic logic [MW-1:0] magn(input logic signed [DW-1:0] v);
        logic [DW-1:0] u;
        u = v[DW-1] ? DW'(-v) : DW'(v);
        return MW'(u);
    endfunction

    // magnitude of one operand, fits in W bits unsigned
    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    logic [MW-1:0] pm, qm, sm, dm, rem_try;
    logic          pneg, qneg, sneg;
    logic [MW:0]   rem_shift;
    logic signed [DW-1:0] prod_p, prod_q;
    logic signed [W-1:0]  incr_sum;
    logic          zero_den, incr_ovf;

    assign prod_p   = DW'(an_reg) * DW'(bd_reg);
    assign prod_q   = DW'(bn_reg) * DW'(ad_reg);
    assign incr_sum = an_reg + ad_reg;
    assign incr_ovf = (an_reg[W-1] == ad_reg[W-1]) && (incr_sum[W-1] != an_reg[W-1]);
    assign zero_den = (ad_reg == '0) || ((kind_reg == rar_pkg::KIND_ADD
                      || kind_reg == rar_pkg::KIND_EQUALS) && bd_reg == '0);

    assign pm   = magn(p_reg);
    assign qm   = magn(q_reg);
    assign pneg = p_reg[DW-1];
    assign qneg = q_reg[DW-1];
    always_comb begin
        if (pneg == qneg) begin
            sm = pm + qm; sneg = pneg;
        end else if (pm >= qm) begin
            sm = pm - qm; sneg = pneg;
        end else begin
            sm = qm - pm; sneg = qneg;
        end
    end
    assign dm = MW'(DW'(mag_w(ad_reg)) * DW'(mag_w(bd_reg)));

    assign rem_shift = {rem_reg, dvd_reg[MW-1]};
    assign rem_try   = rem_shift[MW-1:0] - dvs_reg;

    assign sts.early    = zero_den || kind_reg == rar_pkg::KIND_EQUALS
                          || kind_reg == rar_pkg::KIND_INCR;
    assign sts.div_done = run_reg && (cnt_reg == CW'(0));
    assign sts.y_zero   = (y_reg == '0);

    logic [MW-1:0] lim;
    assign lim = MW'(1) << (W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (cmd.gcd_start || cmd.quot_start || cmd.quot_next) begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(MW - 1);
            end else if (cmd.div_step && run_reg) begin
                if (cnt_reg == CW'(0)) run_reg <= 1'b0;
                else cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind;
            an_reg <= an_in[W-1:0]; ad_reg <= ad_in[W-1:0];
            bn_reg <= bn_in[W-1:0]; bd_reg <= bd_in[W-1:0];
        end
        if (cmd.mul_step) begin
            neg_reg <= 1'b0;
            p_reg   <= prod_p;
            q_reg   <= prod_q;
            if (zero_den) begin
                eq_reg  <= 1'b0;
                num_reg <= '0;
                den_reg <= '0;
                st_reg  <= rar_pkg::STATUS_ZERO_DEN;
            end else begin
                unique case (kind_reg)
                    rar_pkg::KIND_EQUALS: begin
                        eq_reg  <= (prod_p == prod_q);
                        num_reg <= '0;
                        den_reg <= '0;
                        st_reg  <= rar_pkg::STATUS_OK;
                    end
                    rar_pkg::KIND_INCR: begin
                        eq_reg <= 1'b0;
                        if (incr_ovf) begin
                            num_reg <= '0;
                            den_reg <= '0;
                            st_reg  <= rar_pkg::STATUS_OVERFLOW;
                        end else begin
                            num_reg <= FW'(incr_sum);
                            den_reg <= FW'(ad_reg);
                            st_reg  <= rar_pkg::STATUS_OK;
                        end
                    end
                    default: begin
                        eq_reg  <= 1'b0;
                        num_reg <= '0;
                        den_reg <= '0;
                        st_reg  <= rar_pkg::STATUS_OK;
                    end
                endcase
            end
        end
        if (cmd.combine) begin
            if (kind_reg == rar_pkg::KIND_ADD) begin
                nmag_reg <= sm;
                dmag_reg <= dm;
                x_reg    <= sm;
                y_reg    <= dm;
                neg_reg  <= sneg != (ad_reg[W-1] != bd_reg[W-1]);
            end else begin
                nmag_reg <= magn(DW'(an_reg));
                dmag_reg <= magn(DW'(ad_reg));
                x_reg    <= magn(DW'(an_reg));
                y_reg    <= magn(DW'(ad_reg));
                neg_reg  <= an_reg[W-1] != ad_reg[W-1];
            end
        end
        if (cmd.gcd_start) begin
            dvd_reg <= x_reg; dvs_reg <= y_reg; rem_reg <= '0; quo_reg <= '0;
        end
        if (cmd.quot_start) begin
            g_reg <= x_reg;
            dvd_reg <= nmag_reg; dvs_reg <= x_reg; rem_reg <= '0; quo_reg <= '0;
        end
        if (cmd.quot_next) begin
            q1_reg <= {quo_reg[MW-2:0], !rem_shift[MW] && rem_shift[MW-1:0] < dvs_reg
                       ? 1'b0 : 1'b1};
            dvd_reg <= dmag_reg; dvs_reg <= g_reg; rem_reg <= '0; quo_reg <= '0;
        end else if (cmd.div_step && run_reg) begin
            dvd_reg <= {dvd_reg[MW-2:0], 1'b0};
            if (rem_shift[MW] || rem_shift[MW-1:0] >= dvs_reg) begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[MW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[MW-1:0];
                quo_reg <= {quo_reg[MW-2:0], 1'b0};
            end
        end
        if (cmd.gcd_swap) begin
            x_reg <= y_reg;
            y_reg <= (rem_shift[MW] || rem_shift[MW-1:0] >= dvs_reg)
                     ? rem_try : rem_shift[MW-1:0];
        end
        if (cmd.finish) begin
            if (quo_reg > lim - MW'(1) || q1_reg > lim
                || (!(neg_reg && q1_reg != '0) && q1_reg == lim)) begin
                st_reg  <= rar_pkg::STATUS_OVERFLOW;
                num_reg <= '0;
                den_reg <= '0;
            end else begin
                st_reg  <= rar_pkg::STATUS_OK;
                num_reg <= (neg_reg && q1_reg != '0) ? FW'(-q1_reg) : FW'(q1_reg);
                den_reg <= FW'(quo_reg);
            end
        end
    end

    // sign-extend narrow results to the field width
    assign res_num    = FW'(signed'(num_reg[W-1:0]));
    assign res_den    = FW'(signed'(den_reg[W-1:0]));
    assign res_eq     = eq_reg;
    assign res_status = st_reg;

endmodule

### design/rational_add_reduce_unit_top.sv
// rational_add_reduce_unit_top: the rational add/reduce unit
// depends on rar_pkg, rar_ctrl and rar_datapath
//
// one input word carries kind and two fractions a and b; one result word
// follows for every input word
// kind: add and reduce, equality test, increment a, simplify a
// equals, increment and zero-denominator cases form their result in the
// multiply state and skip the gcd and all divisions
// add and simplify run products, a euclidean gcd made of repeated
// restoring divisions and two quotient divisions by the gcd; each gcd
// step is one check state followed by one division, all on the single
// bit-serial divider; the next word can be taken in the same cycle
// that the result shows
// one item is worked on at a time; s_tready is low while busy
// the result sits in an output register; a stalled receiver holds it and
// the unit waits until it is taken
// reset clears the controller, the divider counter and the output valid; no memory to clear
module rational_add_reduce_unit_top #(
    parameter int unsigned OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // a_numerator, a_denominator, b_numerator, b_denominator
    input  logic [1:0]   s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // result_numerator, result_denominator
    output logic [2:0]   m_tuser   // is_equal, status
);

    rar_pkg::rar_cmd_t cmd;
    rar_pkg::rar_sts_t sts;
    logic busy, out_load, s_fire, m_free;
    logic [31:0] res_num, res_den;
    logic        res_eq;
    logic [1:0]  res_status;
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [2:0]  m_user_reg;

    assign s_tready = !busy;
    assign s_fire   = s_tvalid && s_tready;
    assign m_free   = !m_valid_reg || m_tready;

    rar_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire, .m_free, .sts, .cmd, .busy, .out_load
    );

    rar_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .kind(s_tuser),
        .an_in(s_tdata[31:0]), .ad_in(s_tdata[63:32]),
        .bn_in(s_tdata[95:64]), .bd_in(s_tdata[127:96]),
        .res_num, .res_den, .res_eq, .res_status
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= {res_den, res_num};
            m_user_reg <= {res_status, res_eq};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
